### hw/rtl/hdpb_pkg.sv
// ----------------------------------------------------------------------------
// hdpb_pkg
// Shared constants, codes and types of the DPB reference marking unit.
// ----------------------------------------------------------------------------
package hdpb_pkg;

    localparam int DPB_ENTRIES = 16;
    localparam int IDX_W       = $clog2(DPB_ENTRIES);
    localparam int CNT_W       = $clog2(DPB_ENTRIES + 1);
    localparam int POC_W       = 32;
    localparam int SEQ_W       = 8;
    localparam int WORD_W      = POC_W + SEQ_W;

    localparam logic [2:0] CMD_NEW_PIC     = 3'd0;
    localparam logic [2:0] CMD_BEGIN_RPS   = 3'd1;
    localparam logic [2:0] CMD_ADD_REF     = 3'd2;
    localparam logic [2:0] CMD_END_RPS     = 3'd3;
    localparam logic [2:0] CMD_REL_ENTRY   = 3'd4;
    localparam logic [2:0] CMD_REL_ALL     = 3'd5;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_DUP  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic [2:0] MARK_ST  = 3'b001;
    localparam logic [2:0] MARK_LT  = 3'b010;
    localparam logic [2:0] MARK_OUT = 3'b100;

    localparam logic [5:0] TALLY_MAX = 6'd63;

    localparam logic REG_LSB_BITS = 1'b0;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [WORD_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } t_ram_req;

endpackage

### hw/rtl/hdpb_ram.sv
// ----------------------------------------------------------------------------
// hdpb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hdpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/hdpb_engine.sv
// ----------------------------------------------------------------------------
// hdpb_engine
// Command sequencer: walks the POC/sequence RAM, keeps marks and flags,
// and builds one result item per command.
// ----------------------------------------------------------------------------
module hdpb_engine (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [4:0]                   i_lsb_bits,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [2:0]                   i_command,
    input  logic signed [31:0]           i_pic_order,
    input  logic [7:0]                   i_sequence_id,
    input  logic                         i_long_term,
    input  logic                         i_used_by_current,
    input  logic                         i_layer_nonzero,
    input  logic                         i_is_cra,
    input  logic                         i_intra_slice,
    input  logic [3:0]                   i_entry_select,
    input  logic [2:0]                   i_clear_mask,
    output hdpb_pkg::t_ram_req           o_ram,
    input  logic [hdpb_pkg::WORD_W-1:0]  i_ram_rdata,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_status,
    output logic [3:0]                   o_entry_index,
    output logic signed [31:0]           o_entry_poc,
    output logic                         o_missing_ref,
    output logic                         o_cra_flush,
    output logic [5:0]                   o_ref_count
);

    localparam int N     = hdpb_pkg::DPB_ENTRIES;
    localparam int IW    = hdpb_pkg::IDX_W;
    localparam int CW    = hdpb_pkg::CNT_W;
    localparam logic [CW-1:0]   CNT_END = CW'(N);
    localparam logic [IW+3:0]   SEL_LIM = (IW+4)'(N);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_pend, n_pend;
    logic [IW-1:0] r_pidx, n_pidx;

    logic [2:0]  r_cmd;
    logic [31:0] r_poc;
    logic [7:0]  r_seq;
    logic r_lt, r_used, r_layer, r_cra, r_intra;
    logic [3:0] r_sel;
    logic [2:0] r_cmask;

    logic r_fx, n_fx, r_fm, n_fm, r_ff, n_ff, r_flush, n_flush;
    logic [IW-1:0] r_fx_idx, n_fx_idx, r_fm_idx, n_fm_idx, r_ff_idx, n_ff_idx;
    logic [31:0] r_fm_poc, n_fm_poc;

    logic       r_valid [N];
    logic       n_valid [N];
    logic [2:0] r_marks [N];
    logic [2:0] n_marks [N];
    logic       r_error [N];
    logic       n_error [N];
    logic [5:0] r_tally, n_tally;

    logic r_out_valid, n_out_valid;
    logic [1:0]  r_status, n_status;
    logic [3:0]  r_eidx, n_eidx;
    logic [31:0] r_epoc, n_epoc;
    logic r_miss, n_miss, r_oflush, n_oflush;
    logic [5:0] r_count, n_count;

    logic accept;
    logic [31:0] lsb_mask;
    logic [31:0] rd_poc;
    logic [7:0]  rd_seq;
    logic hit_seq, hit_exact, hit_mask, is_free, is_later;
    logic [IW-1:0] tgt;
    logic [31:0] tpoc;
    logic terr, tok;
    logic [2:0] tbase;
    logic [IW+3:0] sel_ext;
    logic [IW+3:0] idx_ext;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign lsb_mask   = 32'((33'd1 << i_lsb_bits) - 33'd1);
    assign rd_poc     = i_ram_rdata[31:0];
    assign rd_seq     = i_ram_rdata[hdpb_pkg::WORD_W-1:32];
    assign sel_ext    = {{IW{1'b0}}, r_sel};

    always_comb begin
        hit_seq   = r_valid[r_pidx] && (rd_seq == r_seq);
        hit_exact = hit_seq && (rd_poc == r_poc);
        hit_mask  = hit_seq && ((rd_poc & lsb_mask) == r_poc);
        is_free   = !r_valid[r_pidx];
        is_later  = r_valid[r_pidx] && (r_marks[r_pidx] != 3'b000)
                    && ($signed(rd_poc) > $signed(r_poc));
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_pend = 1'b0;
        n_pidx = r_pidx;
        n_fx = r_fx; n_fx_idx = r_fx_idx;
        n_fm = r_fm; n_fm_idx = r_fm_idx; n_fm_poc = r_fm_poc;
        n_ff = r_ff; n_ff_idx = r_ff_idx;
        n_flush = r_flush;
        n_valid = r_valid;
        n_marks = r_marks;
        n_error = r_error;
        n_tally = r_tally;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status = r_status; n_eidx = r_eidx; n_epoc = r_epoc;
        n_miss = r_miss; n_oflush = r_oflush; n_count = r_count;
        o_ram.we = 1'b0;
        o_ram.waddr = r_ff_idx;
        o_ram.wdata = {r_seq, r_poc};
        o_ram.raddr = r_cnt[IW-1:0];
        tgt = r_ff_idx; tpoc = r_poc; terr = 1'b0; tok = 1'b0; tbase = 3'b000;
        idx_ext = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cnt = '0;
                    n_fx = 1'b0; n_fm = 1'b0; n_ff = 1'b0; n_flush = 1'b0;
                    if (i_command == hdpb_pkg::CMD_NEW_PIC ||
                        i_command == hdpb_pkg::CMD_ADD_REF ||
                        i_command == hdpb_pkg::CMD_END_RPS) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (r_pend) begin
                    if (!r_fx && hit_exact) begin
                        n_fx = 1'b1; n_fx_idx = r_pidx;
                    end
                    if (!r_fm && hit_mask) begin
                        n_fm = 1'b1; n_fm_idx = r_pidx; n_fm_poc = rd_poc;
                    end
                    if (!r_ff && is_free) begin
                        n_ff = 1'b1; n_ff_idx = r_pidx;
                    end
                    if (is_later) begin
                        n_flush = 1'b1;
                    end
                end
                if (r_cnt != CNT_END) begin
                    n_pend = 1'b1;
                    n_pidx = r_cnt[IW-1:0];
                    n_cnt  = r_cnt + CW'(1);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                    n_status = hdpb_pkg::STATUS_OK;
                    n_eidx = 4'd0; n_epoc = 32'd0;
                    n_miss = 1'b0; n_oflush = 1'b0; n_count = 6'd0;
                    case (r_cmd)
                        hdpb_pkg::CMD_NEW_PIC: begin
                            if (!r_layer && r_fx) begin
                                n_status = hdpb_pkg::STATUS_DUP;
                                idx_ext = {4'd0, r_fx_idx};
                                n_eidx = idx_ext[3:0];
                                n_epoc = r_poc;
                            end else if (r_ff) begin
                                o_ram.we = 1'b1;
                                n_valid[r_ff_idx] = 1'b1;
                                n_marks[r_ff_idx] = hdpb_pkg::MARK_OUT | hdpb_pkg::MARK_ST;
                                n_error[r_ff_idx] = 1'b0;
                                idx_ext = {4'd0, r_ff_idx};
                                n_eidx = idx_ext[3:0];
                                n_epoc = r_poc;
                            end else begin
                                n_status = hdpb_pkg::STATUS_FULL;
                            end
                        end
                        hdpb_pkg::CMD_BEGIN_RPS: begin
                            for (int i = 0; i < N; i++) begin
                                n_marks[i] = r_marks[i] & hdpb_pkg::MARK_OUT;
                            end
                            n_tally = 6'd0;
                        end
                        hdpb_pkg::CMD_ADD_REF: begin
                            if (r_fm) begin
                                tgt = r_fm_idx; tpoc = r_fm_poc; tok = 1'b1;
                                terr = r_error[r_fm_idx]; tbase = r_marks[r_fm_idx];
                            end else if (r_fx) begin
                                tgt = r_fx_idx; tpoc = r_poc; tok = 1'b1;
                                terr = r_error[r_fx_idx]; tbase = r_marks[r_fx_idx];
                            end else if (r_ff) begin
                                tgt = r_ff_idx; tpoc = r_poc; tok = 1'b1;
                                terr = 1'b1; tbase = 3'b000;
                                o_ram.we = 1'b1;
                            end
                            if (tok) begin
                                n_valid[tgt] = 1'b1;
                                n_error[tgt] = terr;
                                n_marks[tgt] = (tbase & hdpb_pkg::MARK_OUT) |
                                               (r_lt ? hdpb_pkg::MARK_LT : hdpb_pkg::MARK_ST);
                                n_miss = terr && r_used;
                                if (r_used && r_tally != hdpb_pkg::TALLY_MAX) begin
                                    n_tally = r_tally + 6'd1;
                                end
                                idx_ext = {4'd0, tgt};
                                n_eidx = idx_ext[3:0];
                                n_epoc = tpoc;
                            end else begin
                                n_status = hdpb_pkg::STATUS_FULL;
                            end
                        end
                        hdpb_pkg::CMD_END_RPS: begin
                            for (int i = 0; i < N; i++) begin
                                if (r_valid[i] && r_marks[i] == 3'b000) begin
                                    n_valid[i] = 1'b0;
                                    n_error[i] = 1'b0;
                                end
                            end
                            n_oflush = r_cra && r_flush;
                            n_count = r_intra ? 6'd0 : r_tally;
                        end
                        hdpb_pkg::CMD_REL_ENTRY: begin
                            if (sel_ext < SEL_LIM) begin
                                tgt = sel_ext[IW-1:0];
                                if (r_valid[tgt]) begin
                                    n_marks[tgt] = r_marks[tgt] & ~r_cmask;
                                    if ((r_marks[tgt] & ~r_cmask) == 3'b000) begin
                                        n_valid[tgt] = 1'b0;
                                        n_error[tgt] = 1'b0;
                                    end
                                end
                            end
                        end
                        hdpb_pkg::CMD_REL_ALL: begin
                            for (int i = 0; i < N; i++) begin
                                if (r_valid[i]) begin
                                    n_marks[i] = r_marks[i] & ~r_cmask;
                                    if ((r_marks[i] & ~r_cmask) == 3'b000) begin
                                        n_valid[i] = 1'b0;
                                        n_error[i] = 1'b0;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    o_ram.waddr = tgt;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_pend <= 1'b0;
            r_fx <= 1'b0; r_fm <= 1'b0; r_ff <= 1'b0; r_flush <= 1'b0;
            for (int i = 0; i < N; i++) begin
                r_valid[i] <= 1'b0;
                r_marks[i] <= 3'b000;
                r_error[i] <= 1'b0;
            end
            r_tally <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_pend <= n_pend;
            r_fx <= n_fx; r_fm <= n_fm; r_ff <= n_ff; r_flush <= n_flush;
            r_valid <= n_valid;
            r_marks <= n_marks;
            r_error <= n_error;
            r_tally <= n_tally;
            r_out_valid <= n_out_valid;
        end
        r_pidx <= n_pidx;
        r_fx_idx <= n_fx_idx; r_fm_idx <= n_fm_idx; r_ff_idx <= n_ff_idx;
        r_fm_poc <= n_fm_poc;
        r_status <= n_status; r_eidx <= n_eidx; r_epoc <= n_epoc;
        r_miss <= n_miss; r_oflush <= n_oflush; r_count <= n_count;
        if (accept) begin
            r_cmd <= i_command;
            r_poc <= i_pic_order;
            r_seq <= i_sequence_id;
            r_lt <= i_long_term;
            r_used <= i_used_by_current;
            r_layer <= i_layer_nonzero;
            r_cra <= i_is_cra;
            r_intra <= i_intra_slice;
            r_sel <= i_entry_select;
            r_cmask <= i_clear_mask;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_index = r_eidx;
    assign o_entry_poc   = r_epoc;
    assign o_missing_ref = r_miss;
    assign o_cra_flush   = r_oflush;
    assign o_ref_count   = r_count;

endmodule

### hw/rtl/hevc_dpb_reference_marking_unit.sv
// ----------------------------------------------------------------------------
// hevc_dpb_reference_marking_unit
// DPB reference marking table: POC/sequence RAM, mark flags, APB register.
//
// channel   direction  handshake                 payload
// input     in         i_in_valid / o_in_ready   command and operands
// result    out        o_out_valid / i_out_ready status, index, POC, flags
// config    APB        psel/penable/pwrite       poc_lsb_bits at 0x0
//
// new_picture, add_ref and end_rps walk the RAM, one entry a cycle, before
// the result step; other commands go straight to the result step.
// Reset is synchronous; the RAM needs no clearing pass.
// A waiting result holds the item in the final step until taken.
// ----------------------------------------------------------------------------
module hevc_dpb_reference_marking_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_pic_order,
    input  logic [7:0]         i_sequence_id,
    input  logic               i_long_term,
    input  logic               i_used_by_current,
    input  logic               i_layer_nonzero,
    input  logic               i_is_cra,
    input  logic               i_intra_slice,
    input  logic [3:0]         i_entry_select,
    input  logic [2:0]         i_clear_mask,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic [3:0]         o_entry_index,
    output logic signed [31:0] o_entry_poc,
    output logic               o_missing_ref,
    output logic               o_cra_flush,
    output logic [5:0]         o_ref_count
);

    logic [4:0] r_lsb_bits;
    hdpb_pkg::t_ram_req ram_req;
    logic [hdpb_pkg::WORD_W-1:0] ram_rdata;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsb_bits <= 5'd8;
        end else if (psel && penable && pwrite && paddr[2] == hdpb_pkg::REG_LSB_BITS) begin
            r_lsb_bits <= pwdata[4:0];
        end
    end

    assign prdata = (paddr[2] == hdpb_pkg::REG_LSB_BITS) ? {27'd0, r_lsb_bits} : 32'd0;

    hdpb_ram #(
        .WIDTH(hdpb_pkg::WORD_W),
        .DEPTH(hdpb_pkg::DPB_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    hdpb_engine u_engine (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_lsb_bits        (r_lsb_bits),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_command         (i_command),
        .i_pic_order       (i_pic_order),
        .i_sequence_id     (i_sequence_id),
        .i_long_term       (i_long_term),
        .i_used_by_current (i_used_by_current),
        .i_layer_nonzero   (i_layer_nonzero),
        .i_is_cra          (i_is_cra),
        .i_intra_slice     (i_intra_slice),
        .i_entry_select    (i_entry_select),
        .i_clear_mask      (i_clear_mask),
        .o_ram             (ram_req),
        .i_ram_rdata       (ram_rdata),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_entry_index     (o_entry_index),
        .o_entry_poc       (o_entry_poc),
        .o_missing_ref     (o_missing_ref),
        .o_cra_flush       (o_cra_flush),
        .o_ref_count       (o_ref_count)
    );

endmodule
